[hdl/cml_pkg.sv]
// Shared types, widths and helpers for the cam motion law evaluator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cml_pkg;

   // Field widths of the stream items and the configuration port.
   localparam int X_W = 17;
   localparam int REG_W = 18;
   localparam int OUT_W = 22;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W = ((X_W + 7) / 8) * 8;
   localparam int RSP_W = ((3 * OUT_W + 7) / 8) * 8;

   // Default number of fraction bits.
   localparam int FRAC_BITS_DEF = 16;

   // Register indexes of the configuration port; higher indexes are unmapped.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAW_MODE  = 3'd0,
      CSR_START_VEL = 3'd1,
      CSR_END_VEL   = 3'd2,
      CSR_START_ACC = 3'd3,
      CSR_END_ACC   = 3'd4
   } csr_index_type;

   // Scaled coefficients stay well inside 36 bits for every legal fraction width.
   localparam int COEF_W = 36;

   // Accumulators clamp to +/- 2^40, so 42 signed bits hold a clamped value plus a coefficient.
   localparam int ACC_LIM_EXP = 40;
   localparam int ACC_W = ACC_LIM_EXP + 2;
   localparam int PROD_W = ACC_W + X_W;

   // Horner steps of the position, velocity and acceleration polynomials.
   localparam int POS_STEPS = 5;
   localparam int VEL_STEPS = 4;
   localparam int ACC_STEPS = 3;
   localparam int CELLS = POS_STEPS;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   localparam acc_type ACC_LIM = acc_type'(64'sd1 << ACC_LIM_EXP);
   localparam acc_type OUT_MAX = acc_type'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
   localparam acc_type OUT_MIN = acc_type'(-(64'sd1 <<< (OUT_W - 1)));

   // One value for each of the three polynomials evaluated side by side.
   typedef struct packed {
      coef_type pos;
      coef_type vel;
      coef_type acc;
   } lane_coef_type;

   typedef struct packed {
      acc_type pos;
      acc_type vel;
      acc_type acc;
   } lane_acc_type;

   // Which polynomials take a Horner step in a given cell.
   typedef struct packed {
      logic pos;
      logic vel;
      logic acc;
   } lane_en_type;

   // Clamp an accumulator to +/- 2^40.
   function automatic acc_type clamp_acc(acc_type v);
      acc_type r;
      r = v;
      if (v > ACC_LIM) begin
         r = ACC_LIM;
      end else if (v < -ACC_LIM) begin
         r = -ACC_LIM;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/cml_coef_unit.sv]
// Configuration registers and motion law coefficient generation.
// Depends on cml_pkg.
`default_nettype none

module cml_coef_unit
   import cml_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wen,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata,
   output lane_coef_type             seed,
   output lane_coef_type             step_coef [CELLS]
);

   // Unity with one extra fraction bit, the scale of the coefficients.
   localparam coef_type ONE = coef_type'(64'sd1 << (FRAC_BITS + 1));

   logic             law_mode_ff;
   logic [REG_W-1:0] start_vel_ff;
   logic [REG_W-1:0] end_vel_ff;
   logic [REG_W-1:0] start_acc_ff;
   logic [REG_W-1:0] end_acc_ff;

   coef_type v0, v1, a0, a1;
   coef_type k5_in, k4_in, k3_in, k2_in, k1_in;
   coef_type k5_ff, k4_ff, k3_ff, k2_ff, k1_ff;
   lane_coef_type seed_in, seed_ff;
   lane_coef_type step_in [CELLS];
   lane_coef_type step_ff [CELLS];

   // Register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         law_mode_ff  <= 1'b0;
         start_vel_ff <= '0;
         end_vel_ff   <= '0;
         start_acc_ff <= '0;
         end_acc_ff   <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_LAW_MODE:  law_mode_ff  <= csr_wdata[0];
            CSR_START_VEL: start_vel_ff <= csr_wdata;
            CSR_END_VEL:   end_vel_ff   <= csr_wdata;
            CSR_START_ACC: start_acc_ff <= csr_wdata;
            CSR_END_ACC:   end_acc_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign v0 = coef_type'(start_vel_ff);
   assign v1 = coef_type'(end_vel_ff);
   assign a0 = coef_type'(start_acc_ff);
   assign a1 = coef_type'(end_acc_ff);

   // Base coefficients of the selected law.
   always_comb begin
      if (law_mode_ff) begin
         k5_in = 6 * ONE - 6 * (v0 + v1) + (a1 - a0);
         k4_in = -15 * ONE + 16 * v0 + 14 * v1 + 3 * a0 - 2 * a1;
         k3_in = 10 * ONE - 12 * v0 - 8 * v1 - 3 * a0 + a1;
         k2_in = a0;
      end else begin
         k5_in = '0;
         k4_in = '0;
         k3_in = -2 * ONE + 2 * v0 + 2 * v1;
         k2_in = 3 * ONE - 4 * v0 - 2 * v1;
      end
      k1_in = 2 * v0;
   end

   always_ff @(posedge clock) begin
      k5_ff <= k5_in;
      k4_ff <= k4_in;
      k3_ff <= k3_in;
      k2_ff <= k2_in;
      k1_ff <= k1_in;
   end

   // Derivative weights and the per-cell addends of each polynomial.
   always_comb begin
      seed_in.pos = k5_ff;
      seed_in.vel = 5 * k5_ff;
      seed_in.acc = 20 * k5_ff;

      step_in[0].pos = k4_ff;
      step_in[0].vel = 4 * k4_ff;
      step_in[0].acc = 12 * k4_ff;

      step_in[1].pos = k3_ff;
      step_in[1].vel = 3 * k3_ff;
      step_in[1].acc = 6 * k3_ff;

      step_in[2].pos = k2_ff;
      step_in[2].vel = 2 * k2_ff;
      step_in[2].acc = 2 * k2_ff;

      step_in[3].pos = k1_ff;
      step_in[3].vel = k1_ff;
      step_in[3].acc = '0;

      step_in[4].pos = '0;
      step_in[4].vel = '0;
      step_in[4].acc = '0;
   end

   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
      step_ff <= step_in;
   end

   assign seed = seed_ff;
   assign step_coef = step_ff;

endmodule

`default_nettype wire

[hdl/cml_cell.sv]
// One Horner cell: multiplies three accumulators by x and adds the next coefficients.
// Depends on cml_pkg.
`default_nettype none

module cml_cell
   import cml_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           adv,
   input  wire lane_en_type    en,
   input  wire lane_coef_type  coef,
   input  wire logic           in_valid,
   input  wire logic [X_W-1:0] in_x,
   input  wire lane_acc_type   in_lanes,
   output logic                out_valid,
   output logic [X_W-1:0]      out_x,
   output lane_acc_type        out_lanes
);

   logic           valid_ff;
   logic [X_W-1:0] x_ff;
   lane_acc_type   lanes_in, lanes_ff;

   // clamp(h) * x, floored by the fraction bits, clamped, plus k.
   function automatic acc_type lane_step(acc_type h, logic [X_W-1:0] x, coef_type k);
      acc_type                  hc;
      logic signed [X_W:0]      xs;
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] shp;
      acc_type                  pc;
      hc = clamp_acc(h);
      xs = {1'b0, x};
      prod = PROD_W'(hc) * PROD_W'(xs);
      shp = prod >>> FRAC_BITS;
      if (shp > PROD_W'(ACC_LIM)) begin
         pc = ACC_LIM;
      end else if (shp < PROD_W'(-ACC_LIM)) begin
         pc = -ACC_LIM;
      end else begin
         pc = shp[ACC_W-1:0];
      end
      return pc + ACC_W'(k);
   endfunction

   // Lanes whose polynomial is already finished pass straight through.
   always_comb begin
      lanes_in.pos = en.pos ? lane_step(in_lanes.pos, in_x, coef.pos) : in_lanes.pos;
      lanes_in.vel = en.vel ? lane_step(in_lanes.vel, in_x, coef.vel) : in_lanes.vel;
      lanes_in.acc = en.acc ? lane_step(in_lanes.acc, in_x, coef.acc) : in_lanes.acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff     <= in_x;
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_lanes = lanes_ff;

endmodule

`default_nettype wire

[hdl/cml_out_buffer.sv]
// Result saturation and the output register with its skid stage.
// Depends on cml_pkg.
`default_nettype none

module cml_out_buffer
   import cml_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lane_acc_type     push_lanes,
   input  wire logic             rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  full
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [RSP_W-1:0] out_data_ff, skid_data_ff, result;
   logic             pop, out_load, out_from_skid, skid_load;

   // Floor by one bit to the output scale, then saturate to the field range.
   function automatic logic [OUT_W-1:0] finish(acc_type h);
      acc_type v;
      v = clamp_acc(h) >>> 1;
      if (v > OUT_MAX) begin
         v = OUT_MAX;
      end else if (v < OUT_MIN) begin
         v = OUT_MIN;
      end
      return v[OUT_W-1:0];
   endfunction

   assign result = {{(RSP_W - 3 * OUT_W){1'b0}}, finish(push_lanes.acc),
                    finish(push_lanes.vel), finish(push_lanes.pos)};

   assign pop = out_valid_ff & rsp_tready;

   // A new result goes to the output register when it is free, else to the skid stage.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_load      = 1'b0;
      out_from_skid = 1'b0;
      skid_load     = 1'b0;
      if (skid_valid_ff) begin
         if (pop) begin
            out_load      = 1'b1;
            out_from_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_load     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_from_skid ? skid_data_ff : result;
      end
      if (skid_load) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign full = skid_valid_ff;

endmodule

`default_nettype wire

[hdl/cam_motion_law_evaluator.sv]
// Top level of the cam motion law evaluator: input alignment, Horner cell chain, output.
// Depends on cml_pkg, cml_coef_unit, cml_cell and cml_out_buffer.
//
// Usage:
//   Each req transfer carries one normalized master position x (16 fraction bits by
//   default). Each rsp transfer returns slave position, velocity and acceleration of the
//   cubic or quintic law chosen through the csr port, saturated to 22 signed bits.
//   Registers are written with csr_wen, csr_index and csr_wdata while no item is in
//   flight; the coefficients derived from them settle through two registers after the write.
// Throughput and pipeline:
//   One item per cycle while the output is not stalled. A result reaches rsp_tvalid
//   through three alignment registers that let fresh coefficients arrive, five
//   Horner cells (one multiply per enabled polynomial each), and the output register.
// Reset:
//   Synchronous and active high. All registers of the law return to zero (cubic law,
//   zero boundary velocities) and the pipeline empties; there is no clearing pass.
// Stall:
//   When rsp_tready is low the output register holds its result and one more result
//   lands in the skid stage; req_tready then drops and the whole chain holds until the
//   skid stage drains. No result is lost or repeated.
`default_nettype none

module cam_motion_law_evaluator
   import cml_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_W-1:0]     req_tdata,   // [16:0] master_pos, rest zero
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,   // slave_pos, slave_vel, slave_acc, zero fill
   input  wire logic                 csr_wen,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata
);

   // Alignment depth: one register more than the coefficient path holds after a write.
   localparam int DLY = 3;

   logic           adv;
   logic           buf_full;
   logic           dly_valid_ff [DLY];
   logic [X_W-1:0] dly_x_ff [DLY];

   lane_coef_type seed;
   lane_coef_type step_coef [CELLS];

   logic           chain_valid [CELLS+1];
   logic [X_W-1:0] chain_x [CELLS+1];
   lane_acc_type   chain_lanes [CELLS+1];

   // The whole chain moves whenever the skid stage is empty.
   assign adv = !buf_full;
   assign req_tready = adv;

   cml_coef_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .seed      (seed),
      .step_coef (step_coef)
   );

   // Input transfer register and alignment line.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DLY; i++) begin
            dly_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         dly_valid_ff[0] <= req_tvalid;
         for (int i = 1; i < DLY; i++) begin
            dly_valid_ff[i] <= dly_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_x_ff[0] <= req_tdata[X_W-1:0];
         for (int i = 1; i < DLY; i++) begin
            dly_x_ff[i] <= dly_x_ff[i-1];
         end
      end
   end

   // The chain starts from the leading coefficient of each polynomial.
   assign chain_valid[0]     = dly_valid_ff[DLY-1];
   assign chain_x[0]         = dly_x_ff[DLY-1];
   assign chain_lanes[0].pos = ACC_W'(seed.pos);
   assign chain_lanes[0].vel = ACC_W'(seed.vel);
   assign chain_lanes[0].acc = ACC_W'(seed.acc);

   for (genvar j = 0; j < CELLS; j++) begin : g_cell
      lane_en_type cell_en;

      assign cell_en.pos = 1'b1;
      assign cell_en.vel = (j < VEL_STEPS);
      assign cell_en.acc = (j < ACC_STEPS);

      cml_cell #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .en        (cell_en),
         .coef      (step_coef[j]),
         .in_valid  (chain_valid[j]),
         .in_x      (chain_x[j]),
         .in_lanes  (chain_lanes[j]),
         .out_valid (chain_valid[j+1]),
         .out_x     (chain_x[j+1]),
         .out_lanes (chain_lanes[j+1])
      );
   end

   // The last cell's x is not needed past the chain.
   cml_out_buffer u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (adv & chain_valid[CELLS]),
      .push_lanes (chain_lanes[CELLS]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .full       (buf_full)
   );

endmodule

`default_nettype wire

[hdl/cml_checker.sv]
// Port-level checks of the cam motion law evaluator, bound to its top level.
// Depends on cml_pkg and cam_motion_law_evaluator.
`default_nettype none

module cml_checker
   import cml_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   // A stalled result holds its value until transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or vanished while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Input back pressure only comes from a stalled output.
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input ready dropped without an output stall");

   // While the input is held off, a buffered result is on offer.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input held off with no result offered");

endmodule

bind cam_motion_law_evaluator cml_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[dv/tb_cam_motion_law_evaluator.sv]
// Testbench for cam_motion_law_evaluator: streams master positions through the block and
// checks every slave position, velocity and acceleration against a built-in predictor.
// Depends on cml_pkg and the RTL of the block; needs no files or arguments.

module tb_cam_motion_law_evaluator;
   timeunit 1ns;
   timeprecision 1ps;

   import cml_pkg::*;

   // Patterns of the result-side ready.
   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_PERIODIC,
      READY_SPARSE
   } ready_style_type;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int ITEM_TARGET = 550;
   localparam int N_ROWS = 18;
   localparam logic [REG_W-1:0] REG_UNIT = REG_W'(1 << FRAC);
   localparam logic [REG_W-1:0] REG_SPAN = REG_W'(2 << FRAC);
   localparam logic [REG_W-1:0] REG_TOP = '1;
   localparam logic [X_W-1:0] X_ONE = X_W'(1 << FRAC);
   localparam logic [X_W-1:0] X_TOP = '1;
   localparam longint HORNER_LIM = 64'sd1 <<< ACC_LIM_EXP;
   localparam longint RESULT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
   localparam longint RESULT_MIN = -(64'sd1 <<< (OUT_W - 1));

   typedef logic signed [OUT_W-1:0] out_type;

   typedef struct packed {
      out_type pos;
      out_type vel;
      out_type acc;
   } motion_type;

   // One directed item together with the law it runs under.
   typedef struct packed {
      logic             quintic;
      logic [REG_W-1:0] v0;
      logic [REG_W-1:0] v1;
      logic [REG_W-1:0] a0;
      logic [REG_W-1:0] a1;
      logic [X_W-1:0]   x;
      logic             typed;
      motion_type       want;
   } law_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;   // [16:0] master_pos, rest zero
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;        // [21:0] slave_pos, [43:22] slave_vel, [65:44] slave_acc
   logic               csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]   csr_wdata = '0;

   // Predictor copy of the law registers, at their reset values.
   logic               law_quintic = 1'b0;
   logic [REG_W-1:0]   law_v0 = '0;
   logic [REG_W-1:0]   law_v1 = '0;
   logic [REG_W-1:0]   law_a0 = '0;
   logic [REG_W-1:0]   law_a1 = '0;

   motion_type  pending_motion [$];
   law_row_type law_rows [N_ROWS];
   int          error_count = 0;
   int          items_sent = 0;
   int          burst_left = 0;

   cam_motion_law_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("[cam_motion_law_evaluator] ERROR");
      $finish;
   end

   // Horner accumulators are held to +/- 2^40.
   function automatic longint clip_horner(longint v);
      if (v > HORNER_LIM) begin
         return HORNER_LIM;
      end else if (v < -HORNER_LIM) begin
         return -HORNER_LIM;
      end
      return v;
   endfunction

   // One Horner step: multiply by x, floor back to the coefficient scale, add k.
   function automatic longint horner_step(longint h, longint x, longint k);
      longint p;
      p = (clip_horner(h) * x) >>> FRAC;
      return clip_horner(p) + k;
   endfunction

   // Drop the extra fraction bit and saturate to the output width.
   function automatic out_type settle_result(longint h);
      longint v;
      v = clip_horner(h) >>> 1;
      if (v > RESULT_MAX) begin
         v = RESULT_MAX;
      end else if (v < RESULT_MIN) begin
         v = RESULT_MIN;
      end
      return out_type'(v);
   endfunction

   // Position, velocity and acceleration of the current law at master position x.
   function automatic motion_type predict_motion(logic [X_W-1:0] master);
      longint one, v0, v1, a0, a1, x;
      longint k5, k4, k3, k2, k1, h;
      motion_type m;
      one = 64'sd1 <<< (FRAC + 1);
      v0 = law_v0;
      v1 = law_v1;
      a0 = law_a0;
      a1 = law_a1;
      x = master;
      // Coefficients carry one fraction bit more than the registers.
      if (law_quintic) begin
         k5 = 6 * one - 6 * (v0 + v1) + (a1 - a0);
         k4 = -15 * one + 16 * v0 + 14 * v1 + 3 * a0 - 2 * a1;
         k3 = 10 * one - 12 * v0 - 8 * v1 - 3 * a0 + a1;
         k2 = a0;
      end else begin
         k5 = 0;
         k4 = 0;
         k3 = -2 * one + 2 * v0 + 2 * v1;
         k2 = 3 * one - 4 * v0 - 2 * v1;
      end
      k1 = 2 * v0;

      h = horner_step(k5, x, k4);
      h = horner_step(h, x, k3);
      h = horner_step(h, x, k2);
      h = horner_step(h, x, k1);
      h = horner_step(h, x, 0);
      m.pos = settle_result(h);

      h = horner_step(5 * k5, x, 4 * k4);
      h = horner_step(h, x, 3 * k3);
      h = horner_step(h, x, 2 * k2);
      h = horner_step(h, x, k1);
      m.vel = settle_result(h);

      h = horner_step(20 * k5, x, 12 * k4);
      h = horner_step(h, x, 6 * k3);
      h = horner_step(h, x, 2 * k2);
      m.acc = settle_result(h);
      return m;
   endfunction

   function automatic law_row_type mk_row(logic q, logic [REG_W-1:0] v0, logic [REG_W-1:0] v1,
                                          logic [REG_W-1:0] a0, logic [REG_W-1:0] a1,
                                          logic [X_W-1:0] x, logic typed,
                                          int pos, int vel, int acc);
      law_row_type r;
      r.quintic = q;
      r.v0 = v0;
      r.v1 = v1;
      r.a0 = a0;
      r.a1 = a1;
      r.x = x;
      r.typed = typed;
      r.want.pos = out_type'(pos);
      r.want.vel = out_type'(vel);
      r.want.acc = out_type'(acc);
      return r;
   endfunction

   // A register value drawn from the style of the current phase.
   function automatic logic [REG_W-1:0] pick_reg(int kind);
      case (kind)
         0: return '0;
         1: return REG_TOP;
         2, 3: return REG_W'($urandom_range(0, 2 << FRAC));
         default: return REG_W'($urandom);
      endcase
   endfunction

   // Mostly positions inside [0,1], some edges and some anywhere in the field.
   function automatic logic [X_W-1:0] pick_position();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return X_ONE;
               2: return X_TOP;
               default: return X_W'(1);
            endcase
         end
         1, 2: return X_W'($urandom);
         default: return X_W'($urandom_range(0, 1 << FRAC));
      endcase
   endfunction

   // Offer one master position in bursts with random gaps; record its result on transfer.
   task automatic send_position(input logic [X_W-1:0] x, input motion_type want);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(x);
      do @(posedge clock); while (!req_tready);
      pending_motion.push_back(want);
      burst_left--;
      items_sent++;
   endtask

   // Stop offering items and wait until every result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_motion.size() != 0) @(posedge clock);
   endtask

   task automatic write_law_reg(input csr_index_type idx, input logic [REG_W-1:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_LAW_MODE:  law_quintic = value[0];
         CSR_START_VEL: law_v0 = value;
         CSR_END_VEL:   law_v1 = value;
         CSR_START_ACC: law_a0 = value;
         CSR_END_ACC:   law_a1 = value;
         default: ;
      endcase
   endtask

   // Load a complete law; a write to an unmapped index goes along and must change nothing.
   task automatic load_law(input logic quintic, input logic [REG_W-1:0] v0,
                           input logic [REG_W-1:0] v1, input logic [REG_W-1:0] a0,
                           input logic [REG_W-1:0] a1);
      logic [REG_W-1:0] mode_word;
      mode_word = REG_W'($urandom);
      mode_word[0] = quintic;
      write_law_reg(csr_index_type'($urandom_range(int'(CSR_END_ACC) + 1,
                                                   (1 << CSR_IDX_W) - 1)),
                    REG_W'($urandom));
      write_law_reg(CSR_LAW_MODE, mode_word);
      write_law_reg(CSR_START_VEL, v0);
      write_law_reg(CSR_END_VEL, v1);
      write_law_reg(CSR_START_ACC, a0);
      write_law_reg(CSR_END_ACC, a1);
      csr_wen <= 1'b0;
   endtask

   task automatic check_field(input string what, input out_type want, input out_type got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   // Result side: ready follows a pattern that is redrawn at random intervals.
   ready_style_type ready_style = READY_ALWAYS;
   int              style_left = 0;
   int              style_tick = 0;

   always @(posedge clock) begin
      if (style_left == 0) begin
         ready_style = ready_style_type'($urandom_range(READY_ALWAYS, READY_SPARSE));
         style_left = $urandom_range(30, 200);
      end
      style_left--;
      style_tick++;
      case (ready_style)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_PERIODIC: rsp_tready <= ((style_tick % 7) < 3);
         default:        rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Compare every result transfer with the oldest pending expectation.
   always @(posedge clock) begin : result_check
      motion_type got;
      motion_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.pos = rsp_tdata[OUT_W-1:0];
         got.vel = rsp_tdata[2*OUT_W-1:OUT_W];
         got.acc = rsp_tdata[3*OUT_W-1:2*OUT_W];
         if (pending_motion.size() == 0) begin
            $display("%0t: unexpected result, expected none, got pos %0d vel %0d acc %0d",
                     $time, got.pos, got.vel, got.acc);
            error_count++;
         end else begin
            want = pending_motion.pop_front();
            check_field("slave_pos", want.pos, got.pos);
            check_field("slave_vel", want.vel, got.vel);
            check_field("slave_acc", want.acc, got.acc);
         end
      end
   end

   initial begin
      law_row_type    row;
      logic [X_W-1:0] x;
      int             kind;

      // Directed items; hand-typed results for the reset law, the default quintic and a
      // straight line. The first rows run on the law left by reset, with no writes at all.
      law_rows[0]  = mk_row(0, 0, 0, 0, 0, '0, 1, 0, 0, 393216);
      law_rows[1]  = mk_row(0, 0, 0, 0, 0, X_ONE, 1, 65536, 0, -393216);
      law_rows[2]  = mk_row(0, 0, 0, 0, 0, X_ONE >> 1, 1, 32768, 98304, 0);
      law_rows[3]  = mk_row(0, 0, 0, 0, 0, X_TOP, 0, 0, 0, 0);
      law_rows[4]  = mk_row(1, 0, 0, 0, 0, '0, 1, 0, 0, 0);
      law_rows[5]  = mk_row(1, 0, 0, 0, 0, X_ONE, 1, 65536, 0, 0);
      law_rows[6]  = mk_row(1, 0, 0, 0, 0, X_TOP, 0, 0, 0, 0);
      // Cubic law with unit velocities is a straight line; the accelerations must not matter.
      law_rows[7]  = mk_row(0, REG_UNIT, REG_UNIT, REG_TOP, REG_TOP, X_ONE >> 1, 1,
                            32768, 65536, 0);
      law_rows[8]  = mk_row(0, REG_TOP, REG_TOP, 0, 0, X_TOP, 0, 0, 0, 0);
      law_rows[9]  = mk_row(0, REG_TOP, REG_TOP, 0, 0, X_ONE, 0, 0, 0, 0);
      law_rows[10] = mk_row(1, REG_TOP, REG_TOP, REG_TOP, REG_TOP, X_TOP, 0, 0, 0, 0);
      law_rows[11] = mk_row(1, REG_TOP, REG_TOP, REG_TOP, REG_TOP, '0, 0, 0, 0, 0);
      law_rows[12] = mk_row(1, REG_TOP, REG_TOP, REG_TOP, REG_TOP, X_W'(1), 0, 0, 0, 0);
      law_rows[13] = mk_row(1, REG_SPAN, 0, REG_SPAN, REG_SPAN, X_ONE, 0, 0, 0, 0);
      law_rows[14] = mk_row(1, REG_SPAN, 0, REG_SPAN, REG_SPAN, X_ONE - 1, 0, 0, 0, 0);
      law_rows[15] = mk_row(1, 0, REG_SPAN, 0, REG_SPAN, X_W'(49152), 0, 0, 0, 0);
      law_rows[16] = mk_row(0, REG_SPAN, REG_SPAN, 0, 0, X_ONE, 0, 0, 0, 0);
      law_rows[17] = mk_row(0, REG_SPAN, REG_SPAN, 0, 0, X_W'(1), 0, 0, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (law_rows[r]) begin
         row = law_rows[r];
         if ({row.quintic, row.v0, row.v1, row.a0, row.a1} !=
             {law_quintic, law_v0, law_v1, law_a0, law_a1}) begin
            drain_results();
            load_law(row.quintic, row.v0, row.v1, row.a0, row.a1);
         end
         send_position(row.x, row.typed ? row.want : predict_motion(row.x));
      end

      // Random phases, each under a freshly loaded law.
      while (items_sent < ITEM_TARGET) begin
         drain_results();
         kind = $urandom_range(0, 5);
         load_law(1'($urandom_range(0, 1)), pick_reg(kind), pick_reg(kind),
                  pick_reg(kind), pick_reg(kind));
         repeat ($urandom_range(20, 70)) begin
            x = pick_position();
            send_position(x, predict_motion(x));
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_motion.size() == 0) begin
         $display("[cam_motion_law_evaluator] OK");
      end else begin
         $display("[cam_motion_law_evaluator] ERROR");
      end
      $finish;
   end

endmodule
